@@ rtl/core/jse_pkg.sv @@
`timescale 1ns / 1ps

package jse_pkg;

   localparam int unsigned MaxResults = 8;

   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_LOW_A   = 8'h61;
   localparam logic [7:0] CH_LOW_B   = 8'h62;
   localparam logic [7:0] CH_LOW_F   = 8'h66;
   localparam logic [7:0] CH_LOW_N   = 8'h6E;
   localparam logic [7:0] CH_LOW_R   = 8'h72;
   localparam logic [7:0] CH_LOW_T   = 8'h74;
   localparam logic [7:0] CH_LOW_U   = 8'h75;
   localparam logic [7:0] CTRL_LIMIT = 8'h20;

   localparam logic [7:0] CODE_BS  = 8'h08;
   localparam logic [7:0] CODE_TAB = 8'h09;
   localparam logic [7:0] CODE_LF  = 8'h0A;
   localparam logic [7:0] CODE_FF  = 8'h0C;
   localparam logic [7:0] CODE_CR  = 8'h0D;

   localparam logic [2:0] LEN_CLEAN = 3'd1;
   localparam logic [2:0] LEN_SHORT = 3'd2;
   localparam logic [2:0] LEN_UNI   = 3'd6;

   localparam logic [15:0] CAP_RESET = 16'hFFFF;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       is_first;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        last_of_item;
      logic        overflow;
      logic [15:0] total_length;
   } rsp_type;

   typedef struct packed {
      rsp_type [MaxResults-1:0] words;
      logic [3:0]               count;
      logic [15:0]              next_written;
      logic                     next_overflow;
   } plan_type;

   // Characters a byte expands to: 1 when clean, 2 for a short escape, 6 for \u00XX.
   function automatic logic [2:0] esc_len(input logic [7:0] c);
      logic [2:0] len;
      len = LEN_CLEAN;
      if (c == CH_QUOTE || c == CH_BSLASH || c == CODE_BS || c == CODE_FF ||
          c == CODE_LF || c == CODE_CR || c == CODE_TAB) begin
         len = LEN_SHORT;
      end else if (c < CTRL_LIMIT) begin
         len = LEN_UNI;
      end
      return len;
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      logic [7:0] d;
      if (v < 4'd10) begin
         d = CH_ZERO + {4'd0, v};
      end else begin
         d = CH_LOW_A + {4'd0, v - 4'd10};
      end
      return d;
   endfunction

   // Character j of the expansion of byte c.
   function automatic logic [7:0] esc_char(input logic [7:0] c, input logic [2:0] j);
      logic [7:0] second;
      logic [7:0] ch;
      unique case (c)
         CODE_BS: second = CH_LOW_B;
         CODE_FF: second = CH_LOW_F;
         CODE_LF: second = CH_LOW_N;
         CODE_CR: second = CH_LOW_R;
         CODE_TAB: second = CH_LOW_T;
         CH_QUOTE, CH_BSLASH: second = c;
         default: second = CH_LOW_U;
      endcase
      if (esc_len(c) == LEN_CLEAN) begin
         ch = c;
      end else begin
         unique case (j)
            3'd0: ch = CH_BSLASH;
            3'd1: ch = second;
            3'd2, 3'd3: ch = CH_ZERO;
            3'd4: ch = hex_digit(c[7:4]);
            default: ch = hex_digit(c[3:0]);
         endcase
      end
      return ch;
   endfunction

endpackage

@@ rtl/core/jse_plan.sv @@
`timescale 1ns / 1ps

module jse_plan (
   input  jse_pkg::req_type  item,
   input  logic [15:0]       written,
   input  logic              overflow_seen,
   input  logic [15:0]       capacity,
   output jse_pkg::plan_type plan
);

   logic        first;
   logic [15:0] s0, s1, s2, s3;
   logic        ov0, ov1, ov2, ov3;
   logic        q1_try, q1_fail, b_try, b_fail, q3_try, q3_fail;
   logic [2:0]  len;
   logic [16:0] need;
   logic        n1, n3;
   logic [2:0]  m;
   logic [3:0]  nvalid;
   logic [3:0]  end_byte;
   logic [3:0]  end_q3;
   logic        marker;
   logic [3:0]  count;
   logic [3:0]  idx;
   logic [2:0]  j;

   always_comb begin
      first = item.is_first;
      s0    = first ? 16'd0 : written;
      ov0   = first ? 1'b0 : overflow_seen;

      q1_try  = first && !ov0;
      q1_fail = q1_try && (s0 >= capacity);
      n1      = q1_try && !q1_fail;
      s1      = s0 + {15'd0, n1};
      ov1     = ov0 | q1_fail;

      len    = jse_pkg::esc_len(item.data_byte);
      need   = (len == jse_pkg::LEN_CLEAN) ? 17'd1 : 17'd6;
      b_try  = item.has_byte && !ov1;
      b_fail = b_try && (({1'b0, s1} + need) >= {1'b0, capacity});
      m      = (b_try && !b_fail) ? len : 3'd0;
      s2     = s1 + {13'd0, m};
      ov2    = ov1 | b_fail;

      q3_try  = item.is_last && !ov2;
      q3_fail = q3_try && (s2 >= capacity);
      n3      = q3_try && !q3_fail;
      s3      = s2 + {15'd0, n3};
      ov3     = ov2 | q3_fail;

      nvalid   = {3'd0, n1} + {1'b0, m} + {3'd0, n3};
      end_byte = {3'd0, n1} + {1'b0, m};
      end_q3   = nvalid;
      marker   = (nvalid == 4'd0) || q1_fail || b_fail || q3_fail;
      count    = nvalid + {3'd0, marker};

      plan = '0;
      for (int i = 0; i < jse_pkg::MaxResults; i++) begin
         idx = 4'(i);
         j   = 3'(idx - {3'd0, n1});
         if (idx < {3'd0, n1}) begin
            plan.words[i].out_byte   = jse_pkg::CH_QUOTE;
            plan.words[i].byte_valid = 1'b1;
         end else if (idx < end_byte) begin
            plan.words[i].out_byte   = jse_pkg::esc_char(item.data_byte, j);
            plan.words[i].byte_valid = 1'b1;
         end else if (idx < end_q3) begin
            plan.words[i].out_byte   = jse_pkg::CH_QUOTE;
            plan.words[i].byte_valid = 1'b1;
         end
         // valid characters count up from the start value; the marker reports the final state
         if (idx < nvalid) begin
            plan.words[i].total_length = s0 + {12'd0, idx} + 16'd1;
            plan.words[i].overflow     = 1'b0;
         end else begin
            plan.words[i].total_length = s3;
            plan.words[i].overflow     = ov3;
         end
         plan.words[i].last_of_item = (idx == count - 4'd1);
      end
      plan.count         = count;
      plan.next_written  = s3;
      plan.next_overflow = ov3;
   end

endmodule

@@ rtl/core/jse_emit.sv @@
`timescale 1ns / 1ps

module jse_emit (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  jse_pkg::plan_type plan,
   output logic              free,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output jse_pkg::rsp_type  rsp_payload
);

   jse_pkg::rsp_type [jse_pkg::MaxResults-1:0] buf_ff, buf_in;
   logic [3:0] cnt_ff, cnt_in;
   logic       take;

   assign take        = rsp_valid && rsp_ready;
   assign free        = (cnt_ff == 4'd0) || ((cnt_ff == 4'd1) && rsp_ready);
   assign rsp_valid   = (cnt_ff != 4'd0);
   assign rsp_payload = buf_ff[0];

   always_comb begin
      buf_in = buf_ff;
      cnt_in = cnt_ff;
      if (load) begin
         buf_in = plan.words;
         cnt_in = plan.count;
      end else if (take) begin
         // advance: next word moves to the head
         for (int k = 0; k < jse_pkg::MaxResults - 1; k++) begin
            buf_in[k] = buf_ff[k+1];
         end
         cnt_in = cnt_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 4'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

endmodule

@@ rtl/core/json_string_escaper.sv @@
`timescale 1ns / 1ps
// Channel  | Ports                          | Word
// ---------+--------------------------------+------------------------------
// request  | req_valid req_ready req_payload | one string byte plus marks
// response | rsp_valid rsp_ready rsp_payload | one escaped character/status
// control  | csr_wr_en csr_wr_data           | output capacity in bytes
//
// An item waits in the input register, then loads as 1 to 8 words
// into the output shift buffer, which drains one word per cycle when rsp_ready
// is high. Clean bytes then run at one item per cycle; an item producing more
// words holds the input until the buffer is down to its last word being taken.
// Reset clears the running count, the overflow flag and sets capacity to 65535.
// A stalled response holds the buffer; the input register then fills and
// req_ready drops.

module json_string_escaper (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  jse_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output jse_pkg::rsp_type rsp_payload,
   input  logic             csr_wr_en,
   input  logic [15:0]      csr_wr_data
);

   jse_pkg::req_type  item_ff, item_in;
   logic              item_vld_ff, item_vld_in;
   logic [15:0]       written_ff, written_in;
   logic              ovf_ff, ovf_in;
   logic [15:0]       cap_ff, cap_in;
   jse_pkg::plan_type plan;
   logic              free;
   logic              load;

   jse_plan u_plan (
      .item          (item_ff),
      .written       (written_ff),
      .overflow_seen (ovf_ff),
      .capacity      (cap_ff),
      .plan          (plan)
   );

   jse_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .plan        (plan),
      .free        (free),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   assign load      = item_vld_ff && free;
   assign req_ready = !item_vld_ff || load;

   always_comb begin
      item_in     = item_ff;
      item_vld_in = item_vld_ff;
      if (req_valid && req_ready) begin
         item_in     = req_payload;
         item_vld_in = 1'b1;
      end else if (load) begin
         item_vld_in = 1'b0;
      end
      written_in = load ? plan.next_written : written_ff;
      ovf_in     = load ? plan.next_overflow : ovf_ff;
      cap_in     = csr_wr_en ? csr_wr_data : cap_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
         written_ff  <= 16'd0;
         ovf_ff      <= 1'b0;
         cap_ff      <= jse_pkg::CAP_RESET;
      end else begin
         item_vld_ff <= item_vld_in;
         written_ff  <= written_in;
         ovf_ff      <= ovf_in;
         cap_ff      <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   a_char_no_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.byte_valid |-> !rsp_payload.overflow)
      else $error("written character flagged as overflow");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> item_vld_ff && !free)
      else $error("input stalled with free room");

   a_item_tail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_payload.last_of_item |=> rsp_valid)
      else $error("item ended without last word");

   a_load_count: assert property (@(posedge clock) disable iff (reset)
      load |-> plan.count != 4'd0 && plan.count <= 4'd8)
      else $error("bad word count on load");

endmodule

@@ dv/json_string_escaper_tb.sv @@
`timescale 1ns / 1ps

module json_string_escaper_tb;

   localparam int CycleLimit  = 1_000_000;
   localparam int PhaseItems  = 50;
   localparam int DrainCycles = 16;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   jse_pkg::req_type  req_payload;
   logic              rsp_valid;
   logic              rsp_ready;
   jse_pkg::rsp_type  rsp_payload;
   logic              csr_wr_en;
   logic [15:0]       csr_wr_data;

   // escaper state as predicted
   int               capacity_now;
   int               run_written;
   logic             run_overflow;
   jse_pkg::rsp_type expected_chars[$];

   int mismatch_count;
   int items_sent;
   int cycle_count;
   bit gaps_on;
   int hold_request;
   int hold_left;
   int stall_left;

   json_string_escaper i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                  expected_chars.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic int escape_form(input logic [7:0] c, output logic [5:0][7:0] seq);
      int len;
      seq = '0;
      seq[0] = jse_pkg::CH_BSLASH;
      len = 2;
      case (c)
         jse_pkg::CH_QUOTE:  seq[1] = jse_pkg::CH_QUOTE;
         jse_pkg::CH_BSLASH: seq[1] = jse_pkg::CH_BSLASH;
         jse_pkg::CODE_BS:   seq[1] = jse_pkg::CH_LOW_B;
         jse_pkg::CODE_FF:   seq[1] = jse_pkg::CH_LOW_F;
         jse_pkg::CODE_LF:   seq[1] = jse_pkg::CH_LOW_N;
         jse_pkg::CODE_CR:   seq[1] = jse_pkg::CH_LOW_R;
         jse_pkg::CODE_TAB:  seq[1] = jse_pkg::CH_LOW_T;
         default: begin
            if (c < jse_pkg::CTRL_LIMIT) begin
               seq[1] = jse_pkg::CH_LOW_U;
               seq[2] = jse_pkg::CH_ZERO;
               seq[3] = jse_pkg::CH_ZERO;
               seq[4] = (c[7:4] < 4'd10) ? jse_pkg::CH_ZERO + c[7:4]
                                         : jse_pkg::CH_LOW_A + (c[7:4] - 4'd10);
               seq[5] = (c[3:0] < 4'd10) ? jse_pkg::CH_ZERO + c[3:0]
                                         : jse_pkg::CH_LOW_A + (c[3:0] - 4'd10);
               len = 6;
            end else begin
               len = 0;
            end
         end
      endcase
      return len;
   endfunction

   function automatic jse_pkg::rsp_type make_word(input logic [7:0] ch, input logic valid);
      jse_pkg::rsp_type w;
      w.out_byte     = valid ? ch : 8'h00;
      w.byte_valid   = valid;
      w.last_of_item = 1'b0;
      w.overflow     = run_overflow;
      w.total_length = 16'(run_written);
      return w;
   endfunction

   function automatic jse_pkg::rsp_type take_char(input logic [7:0] ch);
      run_written++;
      return make_word(ch, 1'b1);
   endfunction

   task automatic predict_escape(input jse_pkg::req_type item);
      jse_pkg::rsp_type burst[8];
      logic [5:0][7:0]  seq;
      int               n;
      int               len;
      logic             failed;
      n = 0;
      failed = 1'b0;
      if (item.is_first) begin
         run_written = 0;
         run_overflow = 1'b0;
      end
      if (item.is_first && !run_overflow) begin
         if (run_written >= capacity_now) begin
            run_overflow = 1'b1;
            failed = 1'b1;
         end else begin
            burst[n] = take_char(jse_pkg::CH_QUOTE);
            n++;
         end
      end
      if (item.has_byte && !run_overflow) begin
         len = escape_form(item.data_byte, seq);
         if (len == 0) begin
            if (run_written + 1 >= capacity_now) begin
               run_overflow = 1'b1;
               failed = 1'b1;
            end else begin
               burst[n] = take_char(item.data_byte);
               n++;
            end
         end else if (run_written + 6 >= capacity_now) begin
            run_overflow = 1'b1;
            failed = 1'b1;
         end else begin
            for (int k = 0; k < len; k++) begin
               burst[n] = take_char(seq[k]);
               n++;
            end
         end
      end
      if (item.is_last && !run_overflow) begin
         if (run_written >= capacity_now) begin
            run_overflow = 1'b1;
            failed = 1'b1;
         end else begin
            burst[n] = take_char(jse_pkg::CH_QUOTE);
            n++;
         end
      end
      // status word: nothing written, or the write that overflowed
      if (n == 0 || failed) begin
         burst[n] = make_word(8'h00, 1'b0);
         n++;
      end
      burst[n-1].last_of_item = 1'b1;
      for (int k = 0; k < n; k++) begin
         expected_chars.push_back(burst[k]);
      end
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 40) begin
         $display("MISMATCH @%0d: %s", cycle_count, msg);
      end
   endtask

   task automatic compare_field(input string name, input logic [15:0] got,
                                input logic [15:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %h want %h", name, got, want));
      end
   endtask

   always @(posedge clock) begin : check_words
      jse_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected word %h", rsp_payload));
         end else begin
            want = expected_chars.pop_front();
            compare_field("out_byte", 16'(rsp_payload.out_byte), 16'(want.out_byte));
            compare_field("byte_valid", 16'(rsp_payload.byte_valid), 16'(want.byte_valid));
            compare_field("last_of_item", 16'(rsp_payload.last_of_item),
                          16'(want.last_of_item));
            compare_field("overflow", 16'(rsp_payload.overflow), 16'(want.overflow));
            compare_field("total_length", rsp_payload.total_length, want.total_length);
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 99) < 30) begin
         stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                   : $urandom_range(9, 29);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- sender

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 60) begin
         return 0;
      end
      if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 25);
   endfunction

   task automatic send_word(input jse_pkg::req_type item);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      predict_escape(item);
      items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] c, input logic first, input logic last);
      jse_pkg::req_type item;
      item.data_byte = c;
      item.has_byte  = 1'b1;
      item.is_first  = first;
      item.is_last   = last;
      send_word(item);
   endtask

   task automatic send_mark(input logic first, input logic last);
      jse_pkg::req_type item;
      item.data_byte = 8'($urandom_range(0, 255));
      item.has_byte  = 1'b0;
      item.is_first  = first;
      item.is_last   = last;
      send_word(item);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [15:0] value);
      wait_drained();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      capacity_now = int'(value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [7:0] pick_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         return 8'($urandom_range(8'h20, 8'h7E));
      end else if (r < 65) begin
         case ($urandom_range(0, 6))
            0: return jse_pkg::CH_QUOTE;
            1: return jse_pkg::CH_BSLASH;
            2: return jse_pkg::CODE_BS;
            3: return jse_pkg::CODE_FF;
            4: return jse_pkg::CODE_LF;
            5: return jse_pkg::CODE_CR;
            default: return jse_pkg::CODE_TAB;
         endcase
      end else if (r < 80) begin
         return 8'($urandom_range(0, 8'h1F));
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // mostly well-formed strings; some with a mark dropped, some pure noise
   task automatic send_random_string();
      jse_pkg::req_type item;
      int               len;
      logic             keep_first;
      logic             keep_last;
      if ($urandom_range(0, 99) < 10) begin
         item = jse_pkg::req_type'(11'($urandom_range(0, 2047)));
         send_word(item);
      end else begin
         len = $urandom_range(0, 11);
         keep_first = ($urandom_range(0, 9) != 0);
         keep_last  = ($urandom_range(0, 9) != 0);
         if (len == 0) begin
            send_mark(keep_first, keep_last);
         end else begin
            for (int i = 0; i < len; i++) begin
               send_byte(pick_char(), keep_first && i == 0, keep_last && i == len - 1);
            end
         end
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_reset_capacity();
      send_mark(1'b1, 1'b1);
      wait_drained();
   endtask

   task automatic test_escape_table();
      send_byte(jse_pkg::CH_QUOTE, 1'b1, 1'b0);
      send_byte(jse_pkg::CH_BSLASH, 1'b0, 1'b0);
      send_byte(jse_pkg::CODE_BS, 1'b0, 1'b0);
      send_byte(jse_pkg::CODE_FF, 1'b0, 1'b0);
      send_byte(jse_pkg::CODE_LF, 1'b0, 1'b0);
      send_byte(jse_pkg::CODE_CR, 1'b0, 1'b0);
      send_byte(jse_pkg::CODE_TAB, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'h1F, 1'b0, 1'b0);
      send_byte(8'h20, 1'b0, 1'b0);
      send_byte(8'h7F, 1'b0, 1'b0);
      send_byte(8'h80, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0);
      send_byte(8'h41, 1'b0, 1'b1);
      // quote, six-char escape, quote: the widest burst
      send_byte(8'h1A, 1'b1, 1'b1);
      wait_drained();
   endtask

   task automatic test_unmarked_items();
      send_byte(8'h41, 1'b0, 1'b0);
      send_mark(1'b0, 1'b0);
      send_mark(1'b0, 1'b1);
      wait_drained();
   endtask

   task automatic test_backpressure();
      int start;
      gaps_on = 1'b0;
      hold_request = 300;
      start = items_sent;
      while (items_sent - start < 40) send_random_string();
      wait_drained();
   endtask

   task automatic test_random_sweep();
      int start;
      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0: write_capacity(16'hFFFF);
            1: write_capacity(16'h0000);
            2: write_capacity(16'h0001);
            3: write_capacity(16'h0002);
            4: write_capacity(16'h0007);
            5: write_capacity(16'h0008);
            6: write_capacity(16'h000D);
            7: write_capacity(16'($urandom_range(3, 40)));
            8: write_capacity(16'($urandom_range(0, 65535)));
            default: write_capacity(16'h0014);
         endcase
         gaps_on = !(phase == 0 || phase == 5);
         start = items_sent;
         while (items_sent - start < PhaseItems) send_random_string();
      end
      wait_drained();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      capacity_now = 65535;
      run_written = 0;
      run_overflow = 1'b0;
      mismatch_count = 0;
      items_sent = 0;
      cycle_count = 0;
      gaps_on = 1'b1;
      hold_request = 0;
      hold_left = 0;
      stall_left = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_capacity();
      test_escape_table();
      test_unmarked_items();
      test_backpressure();
      test_random_sweep();

      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
